[rtl/core/rpiv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rpiv_pkg;

   // Command codes carried in the request.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd1;

   // Reset value of both frame dimensions.
   localparam logic [8:0] DIM_RESET = 9'd256;

   typedef struct packed {
      logic       cmd;
      logic [7:0] row;
      logic [7:0] col;
      logic [7:0] pixel;
   } req_type;

   typedef struct packed {
      logic [3:0] votes;
      logic       addr_error;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/rpiv_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module rpiv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/core/ray_parity_inside_vote_map.sv]
// Writes give no response; the next request is taken in the next cycle.
// A read walks the eight half-rays one pixel per cycle through the frame RAM read port
// and answers with the vote count once the last half-ray is done. An out-of-frame read
// is answered in the next cycle. A new request is taken once the response is accepted.
// Synchronous reset sets both dimensions to 256.
`timescale 1ns / 1ps
`default_nettype none

module ray_parity_inside_vote_map #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  wire rpiv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output rpiv_pkg::rsp_type rsp_data,
   input  wire              csr_we,
   input  wire [1:0]        csr_index,
   input  wire [8:0]        csr_wdata
);

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int DMAX  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int DW    = $clog2(DMAX) + 2;
   localparam int PW    = (DW > 11) ? DW : 11;
   localparam int DEPTH = MAX_ROWS * (2 ** CW);
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic {ST_IDLE, ST_WALK} state_type;

   state_type           state_ff;
   logic [8:0]          height_ff, width_ff;
   logic signed [PW-1:0] q_row_ff, q_col_ff, pos_r_ff, pos_c_ff;
   logic [2:0]          dir_ff;
   logic                pend_ff, have_ff, par_ff;
   logic [7:0]          prev_ff;
   logic [3:0]          votes_ff;
   logic                rsp_valid_ff;
   rpiv_pkg::rsp_type   rsp_ff;

   logic signed [PW-1:0] eff_h, eff_w, req_r, req_c;
   logic signed [PW-1:0] sr, sc, nsr, nsc;
   logic [2:0]           dir_nx;
   logic                 req_in, cur_in, finish, rise, accept, ram_we;
   logic [7:0]           rd_data;
   logic [AW-1:0]        wr_addr, rd_addr;

   function automatic logic in_frame(logic signed [PW-1:0] r, logic signed [PW-1:0] c,
                                     logic signed [PW-1:0] h, logic signed [PW-1:0] w);
      in_frame = (r >= 0) && (c >= 0) && (r < h) && (c < w);
   endfunction

   // Row and column step of a half-ray; odd codes walk backward.
   function automatic logic signed [PW-1:0] row_step(logic [2:0] d);
      logic signed [PW-1:0] s;
      case (d[2:1])
         2'd0:    s = '0;
         2'd1:    s = PW'(1);
         2'd2:    s = PW'(1);
         default: s = -PW'(1);
      endcase
      row_step = d[0] ? -s : s;
   endfunction

   function automatic logic signed [PW-1:0] col_step(logic [2:0] d);
      logic signed [PW-1:0] s;
      s = (d[2:1] == 2'd1) ? '0 : PW'(1);
      col_step = d[0] ? -s : s;
   endfunction

   // Effective frame dimensions: zero acts as one, large values clamp.
   always_comb begin
      if (height_ff == '0) eff_h = PW'(1);
      else if (PW'(height_ff) > PW'(MAX_ROWS)) eff_h = PW'(MAX_ROWS);
      else eff_h = PW'(height_ff);
      if (width_ff == '0) eff_w = PW'(1);
      else if (PW'(width_ff) > PW'(MAX_COLS)) eff_w = PW'(MAX_COLS);
      else eff_w = PW'(width_ff);
   end

   // Request decode and walk control.
   always_comb begin
      req_r   = PW'(req_data.row);
      req_c   = PW'(req_data.col);
      req_in  = in_frame(req_r, req_c, eff_h, eff_w);
      accept  = req_valid && req_ready;
      ram_we  = accept && (req_data.cmd == rpiv_pkg::CMD_WRITE) && req_in;
      wr_addr = {req_r[RW-1:0], req_c[CW-1:0]};
      rd_addr = {pos_r_ff[RW-1:0], pos_c_ff[CW-1:0]};
      sr      = row_step(dir_ff);
      sc      = col_step(dir_ff);
      dir_nx  = dir_ff + 3'd1;
      nsr     = row_step(dir_nx);
      nsc     = col_step(dir_nx);
      cur_in  = in_frame(pos_r_ff, pos_c_ff, eff_h, eff_w);
      finish  = !cur_in && !pend_ff;
      rise    = dir_ff[0] ? (prev_ff > rd_data) : (rd_data > prev_ff);
   end

   rpiv_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_frame (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_addr),
      .wr_data(req_data.pixel),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= rpiv_pkg::DIM_RESET;
         width_ff  <= rpiv_pkg::DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rpiv_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            rpiv_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: walks each half-ray, compares neighbors and counts parity votes.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         have_ff      <= 1'b0;
         par_ff       <= 1'b0;
         dir_ff       <= '0;
         votes_ff     <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_data.cmd == rpiv_pkg::CMD_READ)) begin
                  q_row_ff <= req_r;
                  q_col_ff <= req_c;
                  if (req_in) begin
                     state_ff <= ST_WALK;
                     pos_r_ff <= req_r;
                     pos_c_ff <= req_c;
                     dir_ff   <= '0;
                     pend_ff  <= 1'b0;
                     have_ff  <= 1'b0;
                     par_ff   <= 1'b0;
                     votes_ff <= '0;
                  end else begin
                     rsp_valid_ff      <= 1'b1;
                     rsp_ff.votes      <= '0;
                     rsp_ff.addr_error <= 1'b1;
                  end
               end
            end
            ST_WALK: begin
               // Consume the pixel read in the previous cycle.
               if (pend_ff) begin
                  if (have_ff && rise) par_ff <= !par_ff;
                  prev_ff <= rd_data;
                  have_ff <= 1'b1;
               end
               // Issue the next read while still inside the frame.
               if (cur_in) begin
                  pos_r_ff <= pos_r_ff + sr;
                  pos_c_ff <= pos_c_ff + sc;
               end
               pend_ff <= cur_in;
               if (finish) begin
                  if (dir_ff == 3'd7) begin
                     state_ff          <= ST_IDLE;
                     rsp_valid_ff      <= 1'b1;
                     rsp_ff.votes      <= votes_ff + {3'd0, par_ff};
                     rsp_ff.addr_error <= 1'b0;
                  end else begin
                     votes_ff <= votes_ff + {3'd0, par_ff};
                     dir_ff   <= dir_nx;
                     par_ff   <= 1'b0;
                     have_ff  <= 1'b0;
                     // Backward half-rays start one step away from the query.
                     pos_r_ff <= dir_nx[0] ? q_row_ff + nsr : q_row_ff;
                     pos_c_ff <= dir_nx[0] ? q_col_ff + nsc : q_col_ff;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A response never reports more than eight votes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.votes <= 4'd8))
      else $error("vote count above eight");

   // An address error always comes with zero votes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.addr_error) |-> (rsp_data.votes == '0))
      else $error("address error with nonzero votes");

   // A read is only pending while a walk is in progress.
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_WALK))
      else $error("pending read outside walk");

   // The last direction finishing produces a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && finish && dir_ff == 3'd7) |=> rsp_valid)
      else $error("walk finished without response");

endmodule

`default_nettype wire
